// ===== rtl/phn_pkg.sv =====
// shared types, codes and sizing constants for the pixel histogram normalizer
package phn_pkg;

	// field widths fixed by the interface
	localparam int PIX_W     = 8;
	localparam int CNT_OUT_W = 17;
	localparam int SCALE_W   = 11;
	localparam int STEP_W    = $clog2(SCALE_W + 1);

	// defaults for the top-level parameters
	localparam int NUM_BINS_DEF   = 256;
	localparam int MAX_PIXELS_DEF = 65536;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

	// command codes
	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [PIX_W-1:0] pixel_value;
		logic [PIX_W-1:0] query_bin;
	} in_item_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] bin_count;
		logic [CNT_OUT_W-1:0] peak_count;
		logic [SCALE_W-1:0]   bar_height;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

// ===== rtl/pixel_histogram_normalizer.sv =====
// top level of the pixel histogram normalizer: command decode, bin update pipeline, peak, sweep
// pixel word: one a cycle unless busy; read at accept, incremented and written back next cycle
// query word: read at accept, then a multiply and the divide unit's 11-step quotient loop;
//   busy holds off new words until the result is strobed
// clear word: busy while the bin memory is swept one entry a cycle
// reset: the same sweep runs after reset, config writes are taken throughout
// results are shown for one cycle only; the receiver cannot stall them
module pixel_histogram_normalizer #(
	parameter int NUM_BINS   = phn_pkg::NUM_BINS_DEF,
	parameter int MAX_PIXELS = phn_pkg::MAX_PIXELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  phn_pkg::in_item_t           item,
	output logic                        result_valid,
	output phn_pkg::out_item_t          result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [phn_pkg::SCALE_W-1:0] cfg_data
);

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int EXT_W = (BIN_W > phn_pkg::PIX_W) ? BIN_W : phn_pkg::PIX_W;
	localparam int OUT_W = (CNT_W > phn_pkg::CNT_OUT_W) ? CNT_W : phn_pkg::CNT_OUT_W;
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PIXELS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	// control and state
	phn_pkg::state_t state_q, state_nxt;
	logic [BIN_W-1:0]            clr_cnt_q;
	logic [phn_pkg::SCALE_W-1:0] bar_scale_q;
	logic [CNT_W-1:0]            peak_q;
	logic                        clearing;

	// stage 1: memory data for the word accepted in the previous cycle
	logic             vld_s1;
	logic [1:0]       cmd_s1;
	logic [BIN_W-1:0] addr_s1;
	logic             inrange_s1;

	// query snapshot held for the result
	logic [CNT_W-1:0] res_cnt_q;
	logic [CNT_W-1:0] res_peak_q;

	logic                        accept;
	logic [phn_pkg::PIX_W-1:0]   sel_bin;
	logic [EXT_W-1:0]            sel_ext;
	logic                        sel_inrange;
	logic [CNT_W-1:0]            rd_data;
	logic                        acc_we;
	logic [CNT_W-1:0]            cnt_inc;
	logic                        mem_we;
	logic [BIN_W-1:0]            mem_waddr;
	logic [CNT_W-1:0]            mem_wdata;
	logic                        div_go;
	logic [CNT_W-1:0]            query_cnt;
	phn_pkg::div_status_t        div_st;
	logic [phn_pkg::SCALE_W-1:0] height;
	logic [OUT_W-1:0]            cnt_ext;
	logic [OUT_W-1:0]            peak_ext;

	// busy while sweeping, while a query waits on its memory read, and while dividing
	assign busy   = clearing || (vld_s1 && (cmd_s1 == phn_pkg::CMD_QUERY)) || div_st.busy;
	assign accept = start && !busy;

	// config register: always ready; a query picks up the scale the cycle after its accept
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_scale_q <= phn_pkg::SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bar_scale_q <= cfg_data;
		end
	end

	// sweep state machine: next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			phn_pkg::ST_CLEAR: begin
				if (clr_cnt_q == LAST_BIN) begin
					state_nxt = phn_pkg::ST_RUN;
				end
			end
			phn_pkg::ST_RUN: begin
				if (accept && (item.cmd == phn_pkg::CMD_CLEAR)) begin
					state_nxt = phn_pkg::ST_CLEAR;
				end
			end
			default: state_nxt = phn_pkg::ST_CLEAR;
		endcase
	end

	// sweep state machine: outputs
	always_comb begin
		case (state_q)
			phn_pkg::ST_CLEAR: clearing = 1'b1;
			phn_pkg::ST_RUN:   clearing = 1'b0;
			default:           clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= phn_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (clearing) begin
				clr_cnt_q <= (clr_cnt_q == LAST_BIN) ? '0 : clr_cnt_q + 1'b1;
			end
		end
	end

	// pick the bin the word addresses, and check it against the bin count
	assign sel_bin     = (item.cmd == phn_pkg::CMD_QUERY) ? item.query_bin : item.pixel_value;
	assign sel_ext     = EXT_W'(sel_bin);
	assign sel_inrange = (32'(sel_bin) < 32'(NUM_BINS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= item.cmd;
			addr_s1    <= sel_ext[BIN_W-1:0];
			inrange_s1 <= sel_inrange;
		end
	end

	// increment, saturating at the pixel limit
	assign cnt_inc = rd_data + 1'b1;
	assign acc_we  = vld_s1 && (cmd_s1 == phn_pkg::CMD_PIXEL) && inrange_s1 &&
	                 (rd_data < MAX_CNT);

	// the sweep and a pixel write-back never fall in the same cycle
	assign mem_we    = clearing || acc_we;
	assign mem_waddr = clearing ? clr_cnt_q : addr_s1;
	assign mem_wdata = clearing ? '0 : cnt_inc;

	phn_bin_mem #(
		.DEPTH (NUM_BINS),
		.AW    (BIN_W),
		.DW    (CNT_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (accept),
		.rd_addr (sel_ext[BIN_W-1:0]),
		.rd_data (rd_data)
	);

	// peak follows the bins; zeroed during the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (clearing) begin
			peak_q <= '0;
		end else if (acc_we && (cnt_inc > peak_q)) begin
			peak_q <= cnt_inc;
		end
	end

	// query: snapshot count and peak, hand them to the divide unit
	assign div_go    = vld_s1 && (cmd_s1 == phn_pkg::CMD_QUERY);
	assign query_cnt = inrange_s1 ? rd_data : '0;

	always_ff @(posedge clk) begin
		if (div_go) begin
			res_cnt_q  <= query_cnt;
			res_peak_q <= peak_q;
		end
	end

	phn_div_unit #(
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.count    (query_cnt),
		.peak     (peak_q),
		.scale    (bar_scale_q),
		.status   (div_st),
		.quotient (height)
	);

	// result word, counts masked to the port width
	assign cnt_ext  = OUT_W'(res_cnt_q);
	assign peak_ext = OUT_W'(res_peak_q);

	assign result_valid      = div_st.done;
	assign result.bin_count  = cnt_ext[phn_pkg::CNT_OUT_W-1:0];
	assign result.peak_count = peak_ext[phn_pkg::CNT_OUT_W-1:0];
	assign result.bar_height = height;

endmodule

// ===== rtl/phn_bin_mem.sv =====
// bin count memory: one write and one registered read port, with write-to-read forwarding
module phn_bin_mem #(
	parameter int DEPTH = phn_pkg::NUM_BINS_DEF,
	parameter int AW    = $clog2(phn_pkg::NUM_BINS_DEF),
	parameter int DW    = $clog2(phn_pkg::MAX_PIXELS_DEF + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [AW-1:0] rd_addr_q;
	logic          wr_en_q;
	logic [AW-1:0] wr_addr_q;
	logic [DW-1:0] wr_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= wr_en;
		end
	end

	// a write on the same edge as the read is not yet seen by the array read
	assign rd_data = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : rd_q;

endmodule

// ===== rtl/phn_div_unit.sv =====
// bar height unit: count times scale, then one quotient bit per cycle over the peak
module phn_div_unit #(
	parameter int CNT_W = $clog2(phn_pkg::MAX_PIXELS_DEF + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [CNT_W-1:0]             count,
	input  logic [CNT_W-1:0]             peak,
	input  logic [phn_pkg::SCALE_W-1:0]  scale,
	output phn_pkg::div_status_t         status,
	output logic [phn_pkg::SCALE_W-1:0]  quotient
);

	localparam int SW = phn_pkg::SCALE_W;
	localparam int PW = CNT_W + SW;

	logic                          busy_q;
	logic                          mul_q;
	logic                          done_q;
	logic [phn_pkg::STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              den_q;
	logic [SW-1:0]                 scl_q;
	logic                          zero_q;
	logic [CNT_W-1:0]              rem_q;
	logic [SW-1:0]                 low_q;
	logic [SW-1:0]                 quo_q;

	logic [PW-1:0]    prod;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;

	assign prod  = PW'(cnt_q) * PW'(scl_q);
	assign trial = {rem_q, low_q[SW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
			end else if (mul_q) begin
				mul_q  <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == phn_pkg::STEP_W'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q  <= count;
			den_q  <= peak;
			scl_q  <= scale;
			zero_q <= (peak == '0);
		end else if (mul_q) begin
			// upper product bits are below the peak since count <= peak
			rem_q <= prod[PW-1:SW];
			low_q <= prod[SW-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			low_q <= {low_q[SW-2:0], 1'b0};
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = zero_q ? '0 : quo_q;

endmodule

// ===== rtl/phn_checker.sv =====
// port-level checker for the pixel histogram normalizer, bound to the top level
module phn_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input phn_pkg::in_item_t           item,
	input logic                        result_valid,
	input phn_pkg::out_item_t          result
);

	logic accept;
	assign accept = start && !busy;

	// a query or clear word locks out the next cycle
	a_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((item.cmd == phn_pkg::CMD_QUERY) || (item.cmd == phn_pkg::CMD_CLEAR))
		|=> busy)
		else $error("busy not raised after query or clear word");

	// results are spaced by the divide loop
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// a result only follows a busy cycle
	a_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without preceding busy");

	// a bin never exceeds the peak
	a_cnt_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.bin_count <= result.peak_count))
		else $error("bin count above peak");

	// empty histogram gives flat bars
	a_zero_peak: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.peak_count == '0) |-> (result.bar_height == '0))
		else $error("nonzero height with zero peak");

endmodule

bind pixel_histogram_normalizer phn_checker u_phn_checker (.*);

// ===== sim/phn_result_checker.sv =====
`timescale 1ns / 1ps
// result checker: keeps its own histogram and scale and compares every query result
module phn_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  phn_pkg::in_item_t           item,
	input  logic                        result_valid,
	input  phn_pkg::out_item_t          result,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [phn_pkg::SCALE_W-1:0] cfg_data,
	output int                          pending,
	output int                          mismatches
);

	localparam int BINS     = phn_pkg::NUM_BINS_DEF;
	localparam int BIN_CAP  = phn_pkg::MAX_PIXELS_DEF;

	logic [phn_pkg::CNT_OUT_W-1:0] hist [BINS];
	logic [phn_pkg::CNT_OUT_W-1:0] hist_peak;
	logic [phn_pkg::SCALE_W-1:0]   scale;
	phn_pkg::out_item_t            expected_bars [$];

	always @(posedge clk or negedge arst_n) begin : watch
		phn_pkg::out_item_t          want;
		logic [phn_pkg::PIX_W-1:0]   pix;
		logic [63:0]                 prod;
		if (!arst_n) begin
			foreach (hist[i]) hist[i] = '0;
			hist_peak = '0;
			scale = phn_pkg::SCALE_RESET;
			expected_bars.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				scale = cfg_data;
			if (start && !busy) begin
				case (item.cmd)
				phn_pkg::CMD_PIXEL: begin
					pix = item.pixel_value;
					// a full bin stays where it is
					if (hist[pix] < BIN_CAP) begin
						hist[pix] = hist[pix] + 1'b1;
						if (hist[pix] > hist_peak)
							hist_peak = hist[pix];
					end
				end
				phn_pkg::CMD_QUERY: begin
					want.bin_count  = hist[item.query_bin];
					want.peak_count = hist_peak;
					prod = 64'(hist[item.query_bin]) * 64'(scale);
					want.bar_height = (hist_peak == '0) ? '0 :
						phn_pkg::SCALE_W'(prod / 64'(hist_peak));
					expected_bars.push_back(want);
				end
				phn_pkg::CMD_CLEAR: begin
					foreach (hist[i]) hist[i] = '0;
					hist_peak = '0;
				end
				default: begin
					// unused code, no effect
				end
				endcase
			end
			if (result_valid) begin
				if (expected_bars.size() == 0) begin
					$display("%0t: unexpected result word: expected none, got %p", $time, result);
					mismatches++;
				end else begin
					want = expected_bars.pop_front();
					if (result.bin_count !== want.bin_count) begin
						$display("%0t: bin_count expected %0d, got %0d",
							$time, want.bin_count, result.bin_count);
						mismatches++;
					end
					if (result.peak_count !== want.peak_count) begin
						$display("%0t: peak_count expected %0d, got %0d",
							$time, want.peak_count, result.peak_count);
						mismatches++;
					end
					if (result.bar_height !== want.bar_height) begin
						$display("%0t: bar_height expected %0d, got %0d",
							$time, want.bar_height, result.bar_height);
						mismatches++;
					end
				end
			end
			pending <= expected_bars.size();
		end
	end

endmodule

// ===== sim/tb_pixel_histogram_normalizer.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, command words and scale writes, final verdict
module tb_pixel_histogram_normalizer;

	// longest quiet stretch: post-reset or clear sweep plus the drain pause, with margin
	localparam int WATCHDOG_LIMIT = 2000;
	// the fourth command code, which the block ignores
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam int          PHASE_WORDS = 215;
	localparam logic [phn_pkg::SCALE_W-1:0] SCALE_TOP  = phn_pkg::SCALE_W'(1024);
	localparam logic [phn_pkg::SCALE_W-1:0] SCALE_FULL = '1;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	phn_pkg::in_item_t           item;
	logic                        result_valid;
	phn_pkg::out_item_t          result;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [phn_pkg::SCALE_W-1:0] cfg_data;

	int   pending;
	int   mismatches;
	bit   steady;          // set during stretches with no idle gaps
	logic [7:0] hot [4];   // a few busy grey levels so that bins grow tall

	always #1 clk = ~clk;

	pixel_histogram_normalizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	phn_result_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	// one command word; start stays high on return so back-to-back words need no gap
	task send_word(input logic [1:0] op, input logic [7:0] pix, input logic [7:0] qbin);
		// random idle gap before the word, about 8 in a hundred
		if (!steady && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{op, pix, qbin};
		// busy is sampled before the edge, so the word is taken at the first edge it is low
		do @(posedge clk); while (busy);
	endtask

	task write_scale(input logic [phn_pkg::SCALE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, wait for all query results, then let a pixel write-back or clear sweep finish
	task settle;
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// watchdog: ends the run after too many cycles with no word moving on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_pixel_histogram_normalizer: FAIL");
		$finish;
	end

	initial begin : stimulus
		int          roll;
		logic [1:0]  op;
		logic [7:0]  pix;
		logic [7:0]  qbin;
		logic [phn_pkg::SCALE_W-1:0] phase_scale [4];

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		foreach (hot[i]) hot[i] = 8'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scale write lands while the post-reset sweep is still running
		write_scale(SCALE_TOP);

		// empty histogram: peak zero gives zero height
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd0);
		// both ends of the grey range, plus a middle level
		send_word(phn_pkg::CMD_PIXEL, 8'd0, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd255, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd255, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd128, 8'($urandom));
		// unused code must leave the histogram alone
		send_word(CMD_UNUSED, 8'd255, 8'd255);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd255);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd0);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd1);
		// clear, then read a bin that held counts before
		send_word(phn_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd255);
		// consecutive hits on one bin, back-to-back unless an idle gap falls between, exercise the write-back path
		send_word(phn_pkg::CMD_PIXEL, 8'd255, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd255, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd255, 8'($urandom));
		send_word(phn_pkg::CMD_PIXEL, 8'd0, 8'($urandom));
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd0);
		settle();

		// scale of zero flattens every bar
		write_scale('0);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd255);
		settle();

		// widest scale the register holds
		write_scale(SCALE_FULL);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd0);
		send_word(phn_pkg::CMD_QUERY, 8'($urandom), 8'd255);
		settle();

		// random phases, each under its own scale; the second runs without idle gaps
		phase_scale[0] = SCALE_TOP;
		phase_scale[1] = phn_pkg::SCALE_W'($urandom_range(1, 1024));
		phase_scale[2] = phn_pkg::SCALE_W'(1);
		phase_scale[3] = SCALE_FULL;
		for (int ph = 0; ph < 4; ph++) begin
			write_scale(phase_scale[ph]);
			steady = (ph == 1);
			// fresh histogram so counts grow from zero under this scale
			send_word(phn_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				roll = $urandom_range(99);
				pix  = $urandom_range(1) ? hot[$urandom_range(3)] : 8'($urandom);
				qbin = $urandom_range(1) ? hot[$urandom_range(3)] : 8'($urandom);
				if (roll < 70)
					op = phn_pkg::CMD_PIXEL;
				else if (roll < 94)
					op = phn_pkg::CMD_QUERY;
				else if (roll < 96)
					op = phn_pkg::CMD_CLEAR;
				else if (roll < 98)
					op = CMD_UNUSED;
				else
					op = phn_pkg::CMD_PIXEL;
				send_word(op, pix, qbin);
			end
			steady = 1'b0;
			settle();
		end

		// settle has drained every query and waited out the block's own latency
		if (mismatches == 0)
			$display("tb_pixel_histogram_normalizer: PASS");
		else
			$display("tb_pixel_histogram_normalizer: FAIL");
		$finish;
	end

endmodule
